// File: sv/ostt_pkg.sv
// shared constants, codes and control types for the one-shot timer table
`default_nettype none

package ostt_pkg;

   localparam int SLOTS    = 8;
   localparam int TAG_BITS = 8;
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int CMD_W        = 2;
   localparam int TIME_W       = 32;
   localparam int SLOT_FIELD_W = 3;
   localparam int TAG_FIELD_W  = 8;
   localparam int KIND_W       = 2;

   localparam int NOW_LSB  = 0;
   localparam int TVAL_LSB = NOW_LSB + TIME_W;
   localparam int SLOT_LSB = TVAL_LSB + TIME_W;
   localparam int TAG_LSB  = SLOT_LSB + SLOT_FIELD_W;
   localparam int REQ_USED = TAG_LSB + TAG_FIELD_W;
   localparam int REQ_DATA_W = ((REQ_USED + 7) / 8) * 8;

   localparam int RSP_TAG_LSB = SLOT_FIELD_W;
   localparam int RSP_USED    = SLOT_FIELD_W + TAG_FIELD_W;
   localparam int RSP_DATA_W  = ((RSP_USED + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REG_ABS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REG_REL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_FIRED      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REGISTERED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FULL       = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVED    = 2'd3;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic emit;
      logic exec;
   } ostt_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic scan_last;
      logic mask_empty;
      logic out_free;
   } ostt_stat_type;

endpackage

`default_nettype wire

// File: sv/ostt_ctrl.sv
// controller state machine for the one-shot timer table
`default_nettype none

module ostt_ctrl import ostt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire ostt_stat_type stat,
   output ostt_cmd_type       ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_tready = ready_ff;

   always_comb begin
      ctl.capture   = ready_ff && req_tvalid;
      ctl.scan_step = (state_ff == ST_SCAN);
      ctl.emit      = (state_ff == ST_EMIT) && !stat.mask_empty && stat.out_free;
      ctl.exec      = (state_ff == ST_DECODE) && !stat.is_tick && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (ready_ff && req_tvalid) begin
                  state_ff <= ST_DECODE;
                  ready_ff <= 1'b0;
               end
            end
            ST_DECODE: begin
               if (stat.is_tick) begin
                  state_ff <= ST_SCAN;
               end else if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (stat.mask_empty) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: sv/ostt_dp.sv
// datapath: slot table, expiry scan, result register
`default_nettype none

module ostt_dp import ostt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [CMD_W-1:0]      req_tuser,
   input  wire ostt_cmd_type          ctl,
   output ostt_stat_type              stat,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [KIND_W-1:0]          rsp_tuser,
   output logic                       rsp_tlast
);

   function automatic logic [IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // captured word
   logic [CMD_W-1:0]        cmd_ff;
   logic [TIME_W-1:0]       now_ff;
   logic [TIME_W-1:0]       tval_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic [TAG_BITS-1:0]     tag_ff;

   // slot table
   logic [SLOTS-1:0]    active_ff, active_in;
   logic [TIME_W-1:0]   target_ff [SLOTS];
   logic [TAG_BITS-1:0] action_ff [SLOTS];

   // scan state
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [SLOTS-1:0] mask_ff, mask_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]       out_kind_ff, out_kind_in;
   logic [SLOT_FIELD_W-1:0] out_slot_ff, out_slot_in;
   logic [TAG_FIELD_W-1:0]  out_tag_ff, out_tag_in;
   logic                    out_last_ff, out_last_in;

   logic [TIME_W-1:0] diff;
   logic              reached;
   logic [IDX_W-1:0]  fire_idx;
   logic [SLOTS-1:0]  fire_hot;
   logic [IDX_W-1:0]  free_idx;
   logic              free_found;
   logic [IDX_W-1:0]  rm_idx;
   logic              rm_in_range;
   logic              is_reg;
   logic              do_reg;
   logic [TIME_W-1:0] reg_target;
   logic              out_free;

   assign diff        = now_ff - target_ff[scan_idx_ff];
   assign reached     = ~diff[TIME_W-1];
   assign fire_idx    = lowest_set(mask_ff);
   assign fire_hot    = SLOTS'(1) << fire_idx;
   assign free_idx    = lowest_set(~active_ff);
   assign free_found  = |(~active_ff);
   assign rm_idx      = IDX_W'(slot_ff);
   assign rm_in_range = (int'(slot_ff) < SLOTS);
   assign is_reg      = (cmd_ff == CMD_REG_ABS) || (cmd_ff == CMD_REG_REL);
   assign do_reg      = ctl.exec && is_reg && free_found;
   assign reg_target  = (cmd_ff == CMD_REG_REL) ? (now_ff + tval_ff) : tval_ff;
   assign out_free    = !out_valid_ff || rsp_tready;

   always_comb begin
      stat.is_tick    = (cmd_ff == CMD_TICK);
      stat.scan_last  = (scan_idx_ff == IDX_W'(SLOTS - 1));
      stat.mask_empty = (mask_ff == '0);
      stat.out_free   = out_free;
   end

   always_comb begin
      active_in    = active_ff;
      scan_idx_in  = scan_idx_ff;
      mask_in      = mask_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_slot_in  = out_slot_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;
      if (ctl.capture) begin
         scan_idx_in = '0;
         mask_in     = '0;
      end
      if (ctl.scan_step) begin
         mask_in[scan_idx_ff] = active_ff[scan_idx_ff] && reached;
         scan_idx_in          = scan_idx_ff + IDX_W'(1);
      end
      if (ctl.emit) begin
         active_in[fire_idx] = 1'b0;
         mask_in             = mask_ff & ~fire_hot;
         out_valid_in        = 1'b1;
         out_kind_in         = KIND_FIRED;
         out_slot_in         = SLOT_FIELD_W'(fire_idx);
         out_tag_in          = TAG_FIELD_W'(action_ff[fire_idx]);
         out_last_in         = ((mask_ff & ~fire_hot) == '0);
      end
      if (ctl.exec) begin
         out_valid_in = 1'b1;
         out_tag_in   = TAG_FIELD_W'(tag_ff);
         out_last_in  = 1'b1;
         if (is_reg) begin
            if (free_found) begin
               active_in[free_idx] = 1'b1;
               out_kind_in         = KIND_REGISTERED;
               out_slot_in         = SLOT_FIELD_W'(free_idx);
            end else begin
               out_kind_in = KIND_FULL;
               out_slot_in = '0;
            end
         end else begin
            if (rm_in_range) begin
               active_in[rm_idx] = 1'b0;
            end
            out_kind_in = KIND_REMOVED;
            out_slot_in = slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         out_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
         mask_ff      <= '0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         scan_idx_ff  <= scan_idx_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_slot_ff <= out_slot_in;
      out_tag_ff  <= out_tag_in;
      out_last_ff <= out_last_in;
      if (ctl.capture) begin
         cmd_ff  <= req_tuser;
         now_ff  <= req_tdata[NOW_LSB +: TIME_W];
         tval_ff <= req_tdata[TVAL_LSB +: TIME_W];
         slot_ff <= req_tdata[SLOT_LSB +: SLOT_FIELD_W];
         tag_ff  <= TAG_BITS'(req_tdata[TAG_LSB +: TAG_FIELD_W]);
      end
      if (do_reg) begin
         target_ff[free_idx] <= reg_target;
         action_ff[free_idx] <= tag_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_tag_ff, out_slot_ff});

endmodule

`default_nettype wire

// File: sv/one_shot_timer_table.sv
// top level of the one-shot timer table
//
//  channel | ports  | fields
//  --------+--------+-------------------------------------------------------
//  input   | req_*  | tuser: cmd; tdata: now, time_value, slot, action_tag
//  result  | rsp_*  | tuser: kind; tdata: slot_res, action_tag_res; tlast: last
//
// register and remove words are accepted, then decoded with the result load
// a tick tests one slot per cycle against one
// 32-bit subtractor, then emits one result per fired slot and returns to idle
// reset clears the active bits and the result valid bit; no clearing pass
// a stalled result holds the decode and emit states in place until rsp_tready rises
`default_nettype none

module one_shot_timer_table import ostt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // now, time_value, slot, action_tag
   input  wire logic [CMD_W-1:0]      req_tuser,  // cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // slot_res, action_tag_res
   output logic [KIND_W-1:0]          rsp_tuser,  // kind
   output logic                       rsp_tlast
);

   ostt_cmd_type  ctl;
   ostt_stat_type stat;

   ostt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   ostt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench for the one-shot timer table: directed table, then random episodes
`timescale 1ns / 1ps

module tb_top;
   import ostt_pkg::*;

   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_WORDS  = 150;
   localparam int MAX_FIRED     = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 2 * SLOTS + 12;
   localparam int CYCLE_LIMIT   = 300000;
   localparam logic [TAG_FIELD_W-1:0] TAG_MASK = {TAG_BITS{1'b1}};

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TAG_FIELD_W-1:0]  tag;
      logic                    last;
   } timer_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [TIME_W-1:0]       stamp;
      logic [TIME_W-1:0]       tval;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TAG_FIELD_W-1:0]  tag;
      bit                      typed;
      logic [KIND_W-1:0]       kind;
      logic [SLOT_FIELD_W-1:0] rslot;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // now, time_value, slot, action_tag
   logic [CMD_W-1:0]      req_tuser;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // slot_res, action_tag_res
   logic [KIND_W-1:0]     rsp_tuser;   // kind
   logic                  rsp_tlast;

   // expected state of the slot table
   bit                      exp_armed    [SLOTS];
   logic [TIME_W-1:0]       exp_deadline [SLOTS];
   logic [TAG_FIELD_W-1:0]  exp_tag      [SLOTS];

   timer_result_type step_results[$];
   timer_result_type pending_results[$];
   dir_row_type      dir_rows[$];

   int fail_count      = 0;
   int words_sent      = 0;
   int results_seen    = 0;
   int fired_seen      = 0;
   int full_seen       = 0;
   int max_fired_tick  = 0;
   int cycle_count     = 0;
   bit long_hold_done  = 1'b0;

   always #6 clock = ~clock;

   one_shot_timer_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic timer_result_type make_result(input logic [KIND_W-1:0] kind,
                                                    input logic [SLOT_FIELD_W-1:0] slot,
                                                    input logic [TAG_FIELD_W-1:0] tag,
                                                    input logic last);
      timer_result_type r;
      r.kind = kind;
      r.slot = slot;
      r.tag  = tag;
      r.last = last;
      return r;
   endfunction

   function automatic int pick_gap(input bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // work out the result words that one request word causes, updating the table
   task automatic predict_timers(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_ms,
                                 input logic [TIME_W-1:0] tval,
                                 input logic [SLOT_FIELD_W-1:0] slot,
                                 input logic [TAG_FIELD_W-1:0] tag);
      logic [TIME_W-1:0]       deadline;
      logic [TIME_W-1:0]       lag;
      logic [TAG_FIELD_W-1:0]  tag_kept;
      logic [SLOT_FIELD_W-1:0] slot_idx;
      int                      fired;
      bit                      placed;
      step_results.delete();
      tag_kept = tag & TAG_MASK;
      case (cmd)
         CMD_TICK: begin
            fired = 0;
            for (int i = 0; i < SLOTS; i++) begin
               lag = now_ms - exp_deadline[i];
               if (fired < MAX_FIRED && exp_armed[i] && !lag[TIME_W-1]) begin
                  slot_idx = SLOT_FIELD_W'(i);
                  step_results.push_back(make_result(KIND_FIRED, slot_idx, exp_tag[i], 1'b0));
                  exp_armed[i] = 1'b0;
                  fired++;
               end
            end
            if (fired > 0) step_results[fired-1].last = 1'b1;
            if (fired > max_fired_tick) max_fired_tick = fired;
         end
         CMD_REMOVE: begin
            if (int'(slot) < SLOTS) exp_armed[slot] = 1'b0;
            step_results.push_back(make_result(KIND_REMOVED, slot, tag_kept, 1'b1));
         end
         default: begin
            deadline = (cmd == CMD_REG_REL) ? now_ms + tval : tval;
            placed = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && !exp_armed[i]) begin
                  exp_armed[i]    = 1'b1;
                  exp_deadline[i] = deadline;
                  exp_tag[i]      = tag_kept;
                  slot_idx        = SLOT_FIELD_W'(i);
                  step_results.push_back(make_result(KIND_REGISTERED, slot_idx, tag_kept, 1'b1));
                  placed = 1'b1;
               end
            end
            if (!placed) step_results.push_back(make_result(KIND_FULL, '0, tag_kept, 1'b1));
         end
      endcase
   endtask

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_ms,
                            input logic [TIME_W-1:0] tval, input logic [SLOT_FIELD_W-1:0] slot,
                            input logic [TAG_FIELD_W-1:0] tag, input int gap, input bit typed,
                            input logic [KIND_W-1:0] typed_kind,
                            input logic [SLOT_FIELD_W-1:0] typed_slot);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[NOW_LSB +: TIME_W]        = now_ms;
      word[TVAL_LSB +: TIME_W]       = tval;
      word[SLOT_LSB +: SLOT_FIELD_W] = slot;
      word[TAG_LSB +: TAG_FIELD_W]   = tag;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      do @(posedge clock); while (req_tready !== 1'b1);
      words_sent++;
      predict_timers(cmd, now_ms, tval, slot, tag);
      if (typed) begin
         pending_results.push_back(make_result(typed_kind, typed_slot, tag & TAG_MASK, 1'b1));
      end else begin
         foreach (step_results[k]) pending_results.push_back(step_results[k]);
      end
   endtask

   task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] stamp,
                          input logic [TIME_W-1:0] tval, input logic [SLOT_FIELD_W-1:0] slot,
                          input logic [TAG_FIELD_W-1:0] tag, input bit typed,
                          input logic [KIND_W-1:0] kind, input logic [SLOT_FIELD_W-1:0] rslot);
      dir_row_type row;
      row.cmd   = cmd;
      row.stamp = stamp;
      row.tval  = tval;
      row.slot  = slot;
      row.tag   = tag;
      row.typed = typed;
      row.kind  = kind;
      row.rslot = rslot;
      dir_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("one_shot_timer_table test failed");
         $finish;
      end
   end

   always @(posedge clock) begin : result_check
      timer_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         results_seen++;
         if (rsp_tuser == KIND_FIRED) fired_seen++;
         if (rsp_tuser == KIND_FULL) full_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result word: kind %0d slot %0d tag 0x%02h", rsp_tuser,
                   rsp_tdata[SLOT_FIELD_W-1:0], rsp_tdata[RSP_TAG_LSB +: TAG_FIELD_W]);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[SLOT_FIELD_W-1:0] !== want.slot) begin
               $error("slot_res: expected %0d, got %0d", want.slot, rsp_tdata[SLOT_FIELD_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[RSP_TAG_LSB +: TAG_FIELD_W] !== want.tag) begin
               $error("action_tag_res: expected 0x%02h, got 0x%02h", want.tag,
                      rsp_tdata[RSP_TAG_LSB +: TAG_FIELD_W]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // result side: calm stretches, choppy stretches and one long hold
   initial begin
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!long_hold_done && results_seen >= 30) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold_done = 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end else begin
            repeat ($urandom_range(10, 40)) begin
               @(negedge clock);
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 4) == 0) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
               repeat ($urandom_range(10, 30)) @(negedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      logic [TIME_W-1:0]       clock_ms;
      logic [TIME_W-1:0]       stamp;
      logic [TIME_W-1:0]       tval;
      logic [CMD_W-1:0]        cmd;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TAG_FIELD_W-1:0]  tag;
      int                      random_words;
      int                      pick;
      int                      span;
      int                      live[$];
      bit                      steady;
      bit                      paused;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // removes on an empty table, then fill to the brim with edge targets
      add_row(CMD_REMOVE,  32'h0,         32'h0,         3'd0, 8'hA5, 1, KIND_REMOVED,    3'd0);
      add_row(CMD_REMOVE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1, KIND_REMOVED,    3'd7);
      add_row(CMD_TICK,    32'h0,         32'h0,         3'd0, 8'h00, 0, KIND_FIRED,      3'd0);
      add_row(CMD_REG_ABS, 32'h0,         32'h0,         3'd7, 8'h00, 1, KIND_REGISTERED, 3'd0);
      add_row(CMD_REG_ABS, 32'h0,         32'hFFFF_FFFF, 3'd0, 8'hFF, 1, KIND_REGISTERED, 3'd1);
      add_row(CMD_REG_REL, 32'hFFFF_FFF0, 32'h20,        3'd5, 8'h3C, 1, KIND_REGISTERED, 3'd2);
      add_row(CMD_REG_REL, 32'h0,         32'h7FFF_FFFF, 3'd0, 8'h01, 1, KIND_REGISTERED, 3'd3);
      add_row(CMD_REG_ABS, 32'h0,         32'h8000_0000, 3'd2, 8'h80, 1, KIND_REGISTERED, 3'd4);
      add_row(CMD_REG_ABS, 32'h0,         32'd100,       3'd0, 8'h55, 1, KIND_REGISTERED, 3'd5);
      add_row(CMD_REG_REL, 32'd50,        32'h0,         3'd0, 8'hAA, 1, KIND_REGISTERED, 3'd6);
      add_row(CMD_REG_ABS, 32'h0,         32'd200,       3'd0, 8'h11, 1, KIND_REGISTERED, 3'd7);
      add_row(CMD_REG_ABS, 32'h0,         32'd5,         3'd0, 8'h99, 1, KIND_FULL,       3'd0);
      add_row(CMD_REG_REL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'h42, 1, KIND_FULL,       3'd0);
      add_row(CMD_REMOVE,  32'h0,         32'h0,         3'd3, 8'h24, 1, KIND_REMOVED,    3'd3);
      add_row(CMD_REG_ABS, 32'h0,         32'd60,        3'd0, 8'h77, 1, KIND_REGISTERED, 3'd3);
      // ticks across the wrap and the half-range boundary
      add_row(CMD_TICK,    32'h0,         32'hFFFF_FFFF, 3'd7, 8'hFF, 0, KIND_FIRED,      3'd0);
      add_row(CMD_TICK,    32'h7FFF_FFFF, 32'h0,         3'd0, 8'h00, 0, KIND_FIRED,      3'd0);
      add_row(CMD_TICK,    32'h8000_0000, 32'h0,         3'd0, 8'h00, 0, KIND_FIRED,      3'd0);
      add_row(CMD_TICK,    32'h8000_0000, 32'h0,         3'd0, 8'h00, 0, KIND_FIRED,      3'd0);
      add_row(CMD_REMOVE,  32'h0,         32'h0,         3'd5, 8'h5A, 1, KIND_REMOVED,    3'd5);
      add_row(CMD_REMOVE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd2, 8'h00, 1, KIND_REMOVED,    3'd2);

      foreach (dir_rows[r]) begin
         send_word(dir_rows[r].cmd, dir_rows[r].stamp, dir_rows[r].tval, dir_rows[r].slot,
                   dir_rows[r].tag, pick_gap(1'b0), dir_rows[r].typed, dir_rows[r].kind,
                   dir_rows[r].rslot);
      end

      random_words = 0;
      paused = 1'b0;
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 3))
            0: clock_ms = $urandom;
            1: clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 200);
            2: clock_ms = 32'h7FFF_FF80 + $urandom_range(0, 200);
            default: clock_ms = $urandom_range(0, 100);
         endcase
         steady = ($urandom_range(0, 3) == 0);

         // fill the table, overflow it, then fire a full tick
         if ($urandom_range(0, 2) == 0) begin
            repeat (SLOTS + 1) begin
               tval = $urandom_range(0, 40);
               slot = SLOT_FIELD_W'($urandom);
               tag  = TAG_FIELD_W'($urandom);
               send_word(CMD_REG_REL, clock_ms, tval, slot, tag, pick_gap(steady), 1'b0,
                         KIND_FIRED, '0);
               random_words++;
            end
            clock_ms = clock_ms + 64;
            tval = $urandom;
            slot = SLOT_FIELD_W'($urandom);
            tag  = TAG_FIELD_W'($urandom);
            send_word(CMD_TICK, clock_ms, tval, slot, tag, pick_gap(steady), 1'b0,
                      KIND_FIRED, '0);
            random_words++;
         end

         span = $urandom_range(8, 20);
         repeat (span) begin
            clock_ms = clock_ms + $urandom_range(0, 15);
            stamp = clock_ms;
            tval  = $urandom;
            slot  = SLOT_FIELD_W'($urandom);
            tag   = TAG_FIELD_W'($urandom);
            pick  = $urandom_range(0, 99);
            if (pick < 25) begin
               cmd = CMD_REG_REL;
               if ($urandom_range(0, 9) != 0) tval = $urandom_range(0, 60);
            end else if (pick < 38) begin
               cmd = CMD_REG_ABS;
               if ($urandom_range(0, 4) != 0) tval = clock_ms + $urandom_range(0, 60) - 20;
            end else if (pick < 70) begin
               cmd = CMD_TICK;
            end else if (pick < 88) begin
               cmd = CMD_REMOVE;
               live.delete();
               for (int i = 0; i < SLOTS; i++) if (exp_armed[i]) live.push_back(i);
               if (live.size() > 0 && $urandom_range(0, 4) != 0)
                  slot = SLOT_FIELD_W'(live[$urandom_range(0, live.size() - 1)]);
            end else begin
               // noise: any command at any time
               cmd   = CMD_W'($urandom);
               stamp = $urandom;
            end
            send_word(cmd, stamp, tval, slot, tag, pick_gap(steady), 1'b0, KIND_FIRED, '0);
            random_words++;
         end

         if (!paused && random_words >= RANDOM_WORDS / 2) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
            paused = 1'b1;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words and %0d result words: %0d fired, %0d table full",
               words_sent, results_seen, fired_seen, full_seen);
      $display("up to %0d timers fired by one tick, with a long result stall and a mid-run drain",
               max_fired_tick);
      if (fail_count == 0) begin
         $display("one_shot_timer_table test passed");
      end else begin
         $display("one_shot_timer_table test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/ostt_pkg.sv
sv/ostt_ctrl.sv
sv/ostt_dp.sv
sv/one_shot_timer_table.sv
dv/tb_top.sv
